FILE: sv/pfb_pkg.sv
// Package for the page-mode frame buffer drawing block.
// Holds the action codes, the result type and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package pfb_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_PIXEL = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam int PAGE_ROWS = 8;
  // Column sums need nine bits and row sums eight, set by the input field widths.
  localparam int XS_W = 9;
  localparam int YS_W = 8;

endpackage

FILE: sv/pfb_if.sv
// Handshake channels of the frame buffer block: the action channel and the result channel.
// Depends on pfb_pkg for the action type.
`timescale 1ns / 1ps

interface pfb_in_if;
  import pfb_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] left;
  logic [5:0] top;
  logic [7:0] rect_width;
  logic [6:0] rect_height;
  logic       set_pixels;
  logic [9:0] read_index;

  modport source (
    output valid, action, left, top, rect_width, rect_height, set_pixels, read_index,
    input  ready
  );
  modport sink (
    input  valid, action, left, top, rect_width, rect_height, set_pixels, read_index,
    output ready
  );
endinterface

interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, read_data, rejected, input ready);
  modport sink (input valid, read_data, rejected, output ready);
endinterface

FILE: sv/pfb_store.sv
// Frame store memory: one synchronous read port with registered data and one write port.
// No dependencies.
`timescale 1ns / 1ps

module pfb_store #(
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pfb_seq.sv
// Sequencer of the frame buffer: decodes actions, walks fills and clears,
// and runs the read-modify-write of the frame store. Depends on pfb_pkg and pfb_in_if.
`timescale 1ns / 1ps

module pfb_seq #(
  parameter int COLUMNS = 128,
  parameter int PAGES = 8,
  localparam int ADDR_W = $clog2(COLUMNS * PAGES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfb_in_if.sink            in_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pfb_pkg::res_t     res_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  logic [7:0]        mem_rdata_i,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [7:0]        mem_wdata_o
);
  import pfb_pkg::*;

  localparam int ROWS = PAGES * PAGE_ROWS;
  localparam int STORE_SIZE = COLUMNS * PAGES;
  localparam int COL_W = $clog2(COLUMNS);
  localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic              pend_q, pend_d;
  logic              clr_res_q, clr_res_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [7:0]        pend_mask_q, pend_mask_d;
  logic              pat_q, pat_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [COL_W-1:0]  left_col_q, left_col_d;
  logic [COL_W-1:0]  last_col_q, last_col_d;
  logic [PG_W-1:0]   page_q, page_d;
  logic [PG_W-1:0]   first_pg_q, first_pg_d;
  logic [PG_W-1:0]   last_pg_q, last_pg_d;
  logic [7:0]        first_mask_q, first_mask_d;
  logic [7:0]        last_mask_q, last_mask_d;
  logic              rd_ok_q, rd_ok_d;
  logic              rej_q, rej_d;

  action_e           act;
  logic              accept;
  logic [XS_W-1:0]   right_sum, right_clip;
  logic [YS_W-1:0]   bot_sum, bot_clip, last_row;
  logic              fill_empty, pix_off, rd_ok;
  logic [PG_W-1:0]   in_first_pg, in_last_pg;
  logic [ADDR_W-1:0] pix_addr, fill_addr;
  logic [7:0]        fill_mask, merged;

  assign act        = action_e'(in_i.action);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    right_sum  = XS_W'(in_i.left) + XS_W'(in_i.rect_width);
    right_clip = (right_sum > XS_W'(COLUMNS)) ? XS_W'(COLUMNS) : right_sum;
    bot_sum    = YS_W'(in_i.top) + YS_W'(in_i.rect_height);
    bot_clip   = (bot_sum > YS_W'(ROWS)) ? YS_W'(ROWS) : bot_sum;
    last_row   = bot_clip - YS_W'(1);
    fill_empty = (YS_W'(in_i.top) >= bot_clip) || (XS_W'(in_i.left) >= right_clip);
    pix_off    = (XS_W'(in_i.left) >= XS_W'(COLUMNS)) || (YS_W'(in_i.top) >= YS_W'(ROWS));
    rd_ok      = ($unsigned(32'(in_i.read_index)) < $unsigned(32'(STORE_SIZE)));
    in_first_pg = PG_W'(in_i.top >> 3);
    in_last_pg  = PG_W'(last_row >> 3);
    pix_addr   = ADDR_W'(32'(in_first_pg) * COLUMNS) + ADDR_W'(in_i.left);
    fill_addr  = base_q + ADDR_W'(col_q);
    fill_mask  = ((page_q == first_pg_q) ? first_mask_q : FULL_MASK) &
                 ((page_q == last_pg_q) ? last_mask_q : FULL_MASK);
    merged     = (mem_rdata_i & ~pend_mask_q) | ({8{pat_q}} & pend_mask_q);
  end

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    pend_d       = 1'b0;
    clr_res_d    = clr_res_q;
    pend_addr_d  = pend_addr_q;
    pend_mask_d  = pend_mask_q;
    pat_d        = pat_q;
    col_d        = col_q;
    left_col_d   = left_col_q;
    last_col_d   = last_col_q;
    page_d       = page_q;
    first_pg_d   = first_pg_q;
    last_pg_d    = last_pg_q;
    first_mask_d = first_mask_q;
    last_mask_d  = last_mask_q;
    rd_ok_d      = rd_ok_q;
    rej_d        = rej_q;
    mem_re_o     = 1'b0;
    mem_raddr_o  = fill_addr;
    res_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_ok_d = 1'b0;
          rej_d   = 1'b0;
          pat_d   = in_i.set_pixels;
          unique case (act)
            ACT_CLEAR: begin
              base_d    = '0;
              clr_res_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            ACT_FILL: begin
              base_d       = ADDR_W'(32'(in_first_pg) * COLUMNS);
              col_d        = COL_W'(in_i.left);
              left_col_d   = COL_W'(in_i.left);
              last_col_d   = COL_W'(right_clip - XS_W'(1));
              page_d       = in_first_pg;
              first_pg_d   = in_first_pg;
              last_pg_d    = in_last_pg;
              first_mask_d = FULL_MASK << in_i.top[2:0];
              last_mask_d  = FULL_MASK >> (3'd7 - last_row[2:0]);
              state_d      = fill_empty ? ST_FIN : ST_FILL;
            end
            ACT_PIXEL: begin
              rej_d       = pix_off;
              mem_re_o    = !pix_off;
              mem_raddr_o = pix_addr;
              pend_d      = !pix_off;
              pend_addr_d = pix_addr;
              pend_mask_d = 8'd1 << in_i.top[2:0];
              state_d     = ST_FIN;
            end
            ACT_READ: begin
              rd_ok_d     = rd_ok;
              mem_re_o    = rd_ok;
              mem_raddr_o = ADDR_W'(in_i.read_index);
              state_d     = ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_CLEAR: begin
        if (base_q == ADDR_W'(STORE_SIZE - 1)) begin
          clr_res_d = 1'b0;
          state_d   = clr_res_q ? ST_FIN : ST_IDLE;
        end else begin
          base_d = base_q + ADDR_W'(1);
        end
      end
      ST_FILL: begin
        mem_re_o    = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = fill_addr;
        pend_mask_d = fill_mask;
        if (col_q == last_col_q) begin
          if (page_q == last_pg_q) begin
            state_d = ST_FIN;
          end else begin
            page_d = page_q + PG_W'(1);
            col_d  = left_col_q;
            base_d = base_q + ADDR_W'(COLUMNS);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      ST_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mem_we_o    = (state_q == ST_CLEAR) || pend_q;
  assign mem_waddr_o = (state_q == ST_CLEAR) ? base_q : pend_addr_q;
  assign mem_wdata_o = (state_q == ST_CLEAR) ? 8'd0 : merged;

  assign res_o.read_data = rd_ok_q ? mem_rdata_i : 8'd0;
  assign res_o.rejected  = rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      base_q    <= '0;
      pend_q    <= 1'b0;
      clr_res_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      pend_q    <= pend_d;
      clr_res_q <= clr_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    pend_mask_q  <= pend_mask_d;
    pat_q        <= pat_d;
    col_q        <= col_d;
    left_col_q   <= left_col_d;
    last_col_q   <= last_col_d;
    page_q       <= page_d;
    first_pg_q   <= first_pg_d;
    last_pg_q    <= last_pg_d;
    first_mask_q <= first_mask_d;
    last_mask_q  <= last_mask_d;
    rd_ok_q      <= rd_ok_d;
    rej_q        <= rej_d;
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_q)
    else $error("write still pending while a new transaction can be accepted");

  a_fill_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> ($unsigned(32'(mem_raddr_o)) < $unsigned(32'(STORE_SIZE))))
    else $error("fill address beyond the frame store");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && (state_q != ST_CLEAR)) |-> $past(mem_re_o))
    else $error("merged write without a preceding read");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && !res_ready_i) |=> (state_q == ST_FIN))
    else $error("result dropped before it was taken");
`endif

endmodule

FILE: sv/page_framebuffer_draw.sv
// A pixel write or byte read goes from idle straight to the finish state, and its result is then
// registered in the output stage; a fill walks its bytes and a clear walks the whole store first.
// One read-modify-write per cycle on the single frame store sets the fill rate.
// Only one transaction is handled at a time; a new one is taken only in the idle state.
// Reset: rst_ni clears control state, then a clearing pass over the whole store zeroes it
// while in_i.ready stays low.
`timescale 1ns / 1ps

module page_framebuffer_draw #(
  parameter int COLUMNS = 128,
  parameter int PAGES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfb_in_if.sink     in_i,
  pfb_out_if.source  out_o
);
  import pfb_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              out_valid_q;
  res_t              out_q;

  pfb_seq #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  pfb_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_q.read_data;
  assign out_o.rejected  = out_q.rejected;

endmodule
